// ===== hdl/tlbsa_pkg.sv =====
// shared types, constants and a helper function of the two-level bitmap slot allocator
package tlbsa_pkg;

    localparam int LEAF_WIDTH  = 128;
    localparam int BLOCK_SLOTS = 1024;
    localparam int NUM_SLOTS   = LEAF_WIDTH * LEAF_WIDTH;

    localparam int LEAF_IDX_W  = $clog2(LEAF_WIDTH);
    localparam int SLOT_W      = 2 * LEAF_IDX_W;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);

    localparam int OP_W        = 2;
    localparam int BLK_W       = 4;
    localparam int OFF_W       = 10;
    localparam int ORD_W       = 14;
    localparam int USED_W      = 15;
    localparam int STATUS_W    = 2;

    localparam int FREE_SLOT_W = $clog2(((1 << BLK_W) - 1) * BLOCK_SLOTS + (1 << OFF_W));

    localparam int IN_DATA_W   = ((BLK_W + OFF_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = BLK_W + OFF_W + ORD_W + USED_W + STATUS_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_stat;

    typedef logic [LEAF_WIDTH-1:0] t_word;
    typedef logic [LEAF_IDX_W-1:0] t_leaf_idx;

    // index of lowest set bit, zero when none
    function automatic t_leaf_idx lowest_set(input t_word vec);
        t_leaf_idx idx;
        idx = '0;
        for (int i = LEAF_WIDTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = LEAF_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/tlbsa_ctrl.sv =====
// controller state machine sequencing lookup and commit of each request
module tlbsa_ctrl
    import tlbsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_stat.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tlbsa_datapath.sv =====
// leaf memory, root word, use counter, bit searches and result register
module tlbsa_datapath
    import tlbsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [OP_W-1:0]       i_op,
    input  logic [BLK_W-1:0]      i_free_block,
    input  logic [OFF_W-1:0]      i_free_offset,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    t_word                  r_mem [LEAF_WIDTH];
    logic [LEAF_WIDTH-1:0]  r_valid;
    t_word                  r_root;
    logic [CNT_W-1:0]       r_count;

    t_op                    r_op;
    logic [BLK_W-1:0]       r_fblk;
    logic [OFF_W-1:0]       r_foff;

    t_leaf_idx              r_leaf;
    t_leaf_idx              r_bit;
    logic                   r_in_range;
    logic                   r_avail;
    t_word                  r_rdata;
    logic                   r_rvalid;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    // lookup stage
    logic [FREE_SLOT_W-1:0] free_slot;
    t_leaf_idx              alloc_leaf;
    t_leaf_idx              n_leaf;

    always_comb begin
        free_slot  = FREE_SLOT_W'(r_fblk * BLOCK_SLOTS) + FREE_SLOT_W'(r_foff);
        alloc_leaf = lowest_set(~r_root);
        if (r_op == OP_ALLOC) begin
            n_leaf = alloc_leaf;
        end else begin
            n_leaf = LEAF_IDX_W'(free_slot / LEAF_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= t_op'(i_op);
            r_fblk <= i_free_block;
            r_foff <= i_free_offset;
        end
        if (i_cmd.lookup) begin
            r_leaf     <= n_leaf;
            r_bit      <= LEAF_IDX_W'(free_slot % LEAF_WIDTH);
            r_in_range <= (32'(free_slot) < NUM_SLOTS);
            r_avail    <= (32'(r_count) < NUM_SLOTS);
            r_rdata    <= r_mem[n_leaf];
            r_rvalid   <= r_valid[n_leaf];
        end
    end

    // commit stage
    t_word                  word;
    t_leaf_idx              alloc_bit;
    t_word                  alloc_mask;
    t_word                  free_mask;
    t_word                  alloc_word;
    logic [SLOT_W-1:0]      alloc_slot;
    logic                   do_write;
    t_word                  wr_word;
    logic                   set_root;
    logic                   clr_root;
    logic                   do_clear;
    logic [CNT_W-1:0]       n_count;
    logic [BLK_W-1:0]       res_blk;
    logic [OFF_W-1:0]       res_off;
    logic [ORD_W-1:0]       res_ord;
    t_status                res_status;

    always_comb begin
        word       = r_rvalid ? r_rdata : '0;
        alloc_bit  = lowest_set(~word);
        alloc_mask = t_word'(1) << alloc_bit;
        free_mask  = t_word'(1) << r_bit;
        alloc_word = word | alloc_mask;
        alloc_slot = {r_leaf, alloc_bit};
        do_write   = 1'b0;
        wr_word    = word;
        set_root   = 1'b0;
        clr_root   = 1'b0;
        do_clear   = 1'b0;
        n_count    = r_count;
        res_blk    = '0;
        res_off    = '0;
        res_ord    = '0;
        res_status = STAT_DONE;
        case (r_op)
            OP_ALLOC: begin
                if (r_avail) begin
                    do_write = 1'b1;
                    wr_word  = alloc_word;
                    set_root = &alloc_word;
                    n_count  = r_count + 1'b1;
                    res_blk  = BLK_W'(alloc_slot / BLOCK_SLOTS);
                    res_off  = OFF_W'(alloc_slot % BLOCK_SLOTS);
                    res_ord  = ORD_W'(r_count);
                end else begin
                    res_status = STAT_FULL;
                end
            end
            OP_FREE: begin
                if (!r_in_range || !word[r_bit]) begin
                    res_status = STAT_NOT_ALLOC;
                end else begin
                    do_write = 1'b1;
                    wr_word  = word & ~free_mask;
                    clr_root = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                do_clear = 1'b1;
                n_count  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_write) begin
            r_mem[r_leaf] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_root  <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            if (do_clear) begin
                r_valid <= '0;
                r_root  <= '0;
            end else begin
                if (do_write) begin
                    r_valid[r_leaf] <= 1'b1;
                end
                if (set_root) begin
                    r_root[r_leaf] <= 1'b1;
                end else if (clr_root) begin
                    r_root[r_leaf] <= 1'b0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= OUT_DATA_W'({res_status, USED_W'(n_count), res_ord, res_off, res_blk});
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

endmodule

// ===== hdl/two_level_bitmap_slot_allocator_unit.sv =====
// top level of the two-level bitmap slot allocator
// a request passes the accept, leaf read and commit states of the controller in order;
//   a new request is taken only after the previous one commits, and commit waits while
//   the result register holds a result that is not yet accepted downstream
// reset: synchronous active-low reset frees all slots at once through per-leaf
//   valid bits, clears the root word and the use count; no clearing pass
module two_level_bitmap_slot_allocator_unit
    import tlbsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // free_block, free_offset
    input  logic [OP_W-1:0]       s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // slot_block, slot_offset, use_ordinal,
                                                  // used_count, status
);

    t_cmd  cmd;
    t_stat stat;

    tlbsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tlbsa_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (s_axis_tuser),
        .i_free_block  (s_axis_tdata[BLK_W-1:0]),
        .i_free_offset (s_axis_tdata[BLK_W+OFF_W-1:BLK_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata)
    );

endmodule
